// ----- rtl/thf_pkg.sv -----
// Shared constants, types and helpers of the text head filter.
package thf_pkg;

	localparam int WS_DEPTH = 32;
	localparam int RING_DEPTH = 32;
	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(WS_DEPTH + 1);
	localparam int LEFT_W = $clog2(WS_DEPTH + 20);
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [6:0] MAX_PREFIX = 7'd80;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef enum logic [1:0] {
		REG_HEAD_LINES       = 2'd0,
		REG_TRIM_ENABLE      = 2'd1,
		REG_PREFIX_COLUMNS   = 2'd2,
		REG_FORMFEED_BETWEEN = 2'd3
	} reg_idx_t;

	typedef enum logic {
		MODE_DATA = 1'b0,
		MODE_EOF  = 1'b1
	} mode_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

	typedef struct packed {
		logic [31:0] head_lines;
		logic        trim_enable;
		logic [6:0]  prefix_columns;
		logic        formfeed_between;
	} cfg_t;

	// One unit of output work: formfeed, prefix, held whitespace, final byte.
	typedef struct packed {
		logic               ff;
		logic               pfx;
		logic [CNT_W-1:0]   rd_n;
		logic [RING_AW-1:0] rd_start;
		logic               wr;
		logic [7:0]         wr_byte;
		logic               has_byte;
		logic [7:0]         data;
	} cmd_t;

	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
		logic [7:0]         data;
	} ram_wr_t;

	function automatic logic [6:0] clamp_prefix(input logic [6:0] c);
		return (c > MAX_PREFIX) ? MAX_PREFIX : c;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SP) || (b == CH_TAB) || (b == CH_VT) || (b == CH_CR);
	endfunction

endpackage

// ----- rtl/thf_ifs.sv -----
// Valid/ready channel interfaces for input items and output words.
interface thf_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] in_byte;

	modport source(output valid, output mode, output in_byte, input ready);
	modport sink(input valid, input mode, input in_byte, output ready);
endinterface

interface thf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source(output valid, output out_byte, output last_of_run, input ready);
	modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- rtl/thf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module thf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/thf_queue.sv -----
// Short command queue between the front and back parts.
module thf_queue import thf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	cmd_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/thf_front.sv -----
// Front part: accepts items, tracks line and whitespace state, issues commands.
module thf_front import thf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	thf_in_if.sink  in_ch,
	input  logic    q_full,
	input  logic    drain_busy,
	output logic    push,
	output cmd_t    push_cmd,
	output ram_wr_t ram_wr
);

	logic [31:0]        line_count_q, line_count_d;
	logic               head_done_q, head_done_d;
	logic               has_text_q, has_text_d;
	logic [CNT_W-1:0]   pcount_q, pcount_d;
	logic [RING_AW-1:0] phead_q, phead_d;
	logic               not_first_q, not_first_d;
	logic               file_begun_q, file_begun_d;

	logic        trimming;
	logic        data_live;
	logic        is_term;
	logic        ws_item;
	logic        acc;
	logic [31:0] lc_inc;
	logic [7:0]  b;
	cmd_t        cmd;

	assign b         = in_ch.in_byte;
	assign trimming  = cfg.trim_enable || (cfg.prefix_columns != '0);
	assign is_term   = (b == CH_LF) || (b == CH_FF);
	assign data_live = (in_ch.mode == MODE_DATA) && !head_done_q && (b != CH_NUL);
	assign ws_item   = data_live && !is_term && trimming && is_blank(b);
	// Hold whitespace only once no queued work still reads the ring.
	assign in_ch.ready = !q_full && !(ws_item && drain_busy);
	assign acc       = in_ch.valid && in_ch.ready;
	assign lc_inc    = line_count_q + 32'd1;

	always_comb begin
		cmd          = '0;
		ram_wr       = '0;
		line_count_d = line_count_q;
		head_done_d  = head_done_q;
		has_text_d   = has_text_q;
		pcount_d     = pcount_q;
		phead_d      = phead_q;
		not_first_d  = not_first_q;
		file_begun_d = 1'b1;
		cmd.ff       = !file_begun_q && cfg.formfeed_between && not_first_q;

		if (in_ch.mode == MODE_EOF) begin
			pcount_d     = '0;
			phead_d      = '0;
			line_count_d = '0;
			head_done_d  = 1'b0;
			has_text_d   = 1'b0;
			not_first_d  = 1'b1;
			file_begun_d = 1'b0;
		end else if (data_live) begin
			if (is_term) begin
				if (!trimming && (pcount_q != '0)) begin
					cmd.pfx      = !has_text_q;
					cmd.rd_n     = pcount_q;
					cmd.rd_start = phead_q;
				end
				pcount_d     = '0;
				phead_d      = '0;
				cmd.has_byte = 1'b1;
				cmd.data     = b;
				has_text_d   = 1'b0;
				line_count_d = lc_inc;
				if (lc_inc >= cfg.head_lines) begin
					head_done_d = 1'b1;
				end
			end else if (ws_item) begin
				if (pcount_q >= CNT_W'(WS_DEPTH)) begin
					// Ring full: release the oldest byte, back rewrites its slot.
					cmd.pfx      = !has_text_q;
					cmd.rd_n     = CNT_W'(1);
					cmd.rd_start = phead_q;
					cmd.wr       = 1'b1;
					cmd.wr_byte  = b;
					has_text_d   = 1'b1;
					phead_d      = phead_q + RING_AW'(1);
				end else begin
					ram_wr.en   = acc;
					ram_wr.addr = phead_q + pcount_q[RING_AW-1:0];
					ram_wr.data = b;
					pcount_d    = pcount_q + CNT_W'(1);
				end
			end else begin
				cmd.pfx      = !has_text_q;
				cmd.rd_n     = pcount_q;
				cmd.rd_start = phead_q;
				cmd.has_byte = 1'b1;
				cmd.data     = b;
				has_text_d   = 1'b1;
				pcount_d     = '0;
				phead_d      = '0;
			end
		end
	end

	assign push     = acc && (cmd.ff || cmd.has_byte || (cmd.rd_n != '0));
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
			head_done_q  <= 1'b0;
			has_text_q   <= 1'b0;
			pcount_q     <= '0;
			phead_q      <= '0;
			not_first_q  <= 1'b0;
			file_begun_q <= 1'b0;
		end else if (acc) begin
			line_count_q <= line_count_d;
			head_done_q  <= head_done_d;
			has_text_q   <= has_text_d;
			pcount_q     <= pcount_d;
			phead_q      <= phead_d;
			not_first_q  <= not_first_d;
			file_begun_q <= file_begun_d;
		end
	end

endmodule

// ----- rtl/thf_back.sv -----
// Back part: expands each command into output words through the output register.
module thf_back import thf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [6:0]         prefix_columns,
	input  logic               q_empty,
	output logic               pop,
	input  cmd_t               pop_cmd,
	output logic [RING_AW-1:0] ram_rd_addr,
	input  logic [7:0]         ram_rd_data,
	output ram_wr_t            ram_wr,
	output logic               busy,
	thf_out_if.source          out_ch
);

	bk_state_t state_q, state_d;

	logic               ff_q;
	logic [3:0]         tab_q;
	logic [2:0]         spc_q;
	logic [CNT_W-1:0]   rd_q;
	logic               wr_q;
	logic               byte_q;
	logic               rd_ok_q;
	logic [RING_AW-1:0] ptr_q;
	logic [7:0]         wr_byte_q;
	logic [7:0]         data_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic [6:0]        cols;
	logic [LEFT_W-1:0] left;
	logic              out_free;
	logic              need_rd;
	logic              emit;
	logic [7:0]        emit_byte;

	assign cols     = clamp_prefix(prefix_columns);
	assign left     = LEFT_W'(ff_q) + LEFT_W'(tab_q) + LEFT_W'(spc_q) + LEFT_W'(rd_q)
		+ LEFT_W'(byte_q);
	assign out_free = !out_valid_q || out_ch.ready;
	assign need_rd  = !ff_q && (tab_q == '0) && (spc_q == '0) && (rd_q != '0);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				// Wait for ring data after the read address moves.
				emit = out_free && (!need_rd || rd_ok_q);
				if (emit && (left == LEFT_W'(1))) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		if (ff_q) begin
			emit_byte = CH_FF;
		end else if (tab_q != '0) begin
			emit_byte = CH_TAB;
		end else if (spc_q != '0) begin
			emit_byte = CH_SP;
		end else if (rd_q != '0) begin
			emit_byte = ram_rd_data;
		end else begin
			emit_byte = data_q;
		end
	end

	assign ram_rd_addr = ptr_q;
	assign ram_wr.en   = emit && need_rd && (rd_q == CNT_W'(1)) && wr_q;
	assign ram_wr.addr = ptr_q;
	assign ram_wr.data = wr_byte_q;
	assign busy        = (state_q != BK_IDLE);

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.last_of_run = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_q        <= 1'b0;
			tab_q       <= '0;
			spc_q       <= '0;
			rd_q        <= '0;
			wr_q        <= 1'b0;
			byte_q      <= 1'b0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Read data is stale right after the read address moves.
			rd_ok_q <= !(pop || (emit && need_rd));
			if (pop) begin
				ff_q    <= pop_cmd.ff;
				tab_q   <= pop_cmd.pfx ? cols[6:3] : 4'd0;
				spc_q   <= pop_cmd.pfx ? cols[2:0] : 3'd0;
				rd_q    <= pop_cmd.rd_n;
				wr_q    <= pop_cmd.wr;
				byte_q  <= pop_cmd.has_byte;
			end else if (emit) begin
				if (ff_q) begin
					ff_q <= 1'b0;
				end else if (tab_q != '0) begin
					tab_q <= tab_q - 4'd1;
				end else if (spc_q != '0) begin
					spc_q <= spc_q - 3'd1;
				end else if (rd_q != '0) begin
					rd_q    <= rd_q - CNT_W'(1);
				end else begin
					byte_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ptr_q     <= pop_cmd.rd_start;
			wr_byte_q <= pop_cmd.wr_byte;
			data_q    <= pop_cmd.data;
		end else if (emit && need_rd) begin
			ptr_q <= ptr_q + RING_AW'(1);
		end
		if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= (left == LEFT_W'(1));
		end
	end

endmodule

// ----- rtl/text_head_filter_unit.sv -----
// Top level of the text head filter: config registers, front, queue, back, ring RAM.
//
//   Channel   Dir  Handshake            Payload
//   in_ch     in   valid / ready        mode, in_byte
//   out_ch    out  valid / ready        out_byte, last_of_run
//   cfg       in   cfg_we (no stall)    cfg_index, cfg_data
//
// The front takes one item a cycle while the 4-entry command queue has room.
// A whitespace byte that is held waits until the queue and back part are empty.
// The back takes a command while idle, then sends one word a cycle when out_ch is ready;
// a held whitespace word also waits for the registered ring read after each address move.
// Reset is asynchronous and active low; the ring RAM needs no clearing pass.
module text_head_filter_unit import thf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	thf_in_if.sink      in_ch,
	thf_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t               cfg_q;
	logic               push;
	cmd_t               push_cmd;
	logic               q_full;
	logic               q_empty;
	logic               pop;
	cmd_t               pop_cmd;
	logic               back_busy;
	ram_wr_t            front_wr;
	ram_wr_t            back_wr;
	ram_wr_t            ram_wr;
	logic [RING_AW-1:0] ram_rd_addr;
	logic [7:0]         ram_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_lines       <= 32'd10;
			cfg_q.trim_enable      <= 1'b0;
			cfg_q.prefix_columns   <= 7'd0;
			cfg_q.formfeed_between <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_HEAD_LINES:       cfg_q.head_lines       <= cfg_data;
				REG_TRIM_ENABLE:      cfg_q.trim_enable      <= cfg_data[0];
				REG_PREFIX_COLUMNS:   cfg_q.prefix_columns   <= cfg_data[6:0];
				REG_FORMFEED_BETWEEN: cfg_q.formfeed_between <= cfg_data[0];
				default: ;
			endcase
		end
	end

	thf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_ch      (in_ch),
		.q_full     (q_full),
		.drain_busy (!q_empty || back_busy),
		.push       (push),
		.push_cmd   (push_cmd),
		.ram_wr     (front_wr)
	);

	thf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	thf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.prefix_columns (cfg_q.prefix_columns),
		.q_empty        (q_empty),
		.pop            (pop),
		.pop_cmd        (pop_cmd),
		.ram_rd_addr    (ram_rd_addr),
		.ram_rd_data    (ram_rd_data),
		.ram_wr         (back_wr),
		.busy           (back_busy),
		.out_ch         (out_ch)
	);

	assign ram_wr = back_wr.en ? back_wr : front_wr;

	thf_ram #(
		.WIDTH (8),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.raddr (ram_rd_addr),
		.rdata (ram_rd_data)
	);

	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(front_wr.en && back_wr.en))
		else $error("ring written by front and back in one cycle");

	a_front_write_drained: assert property (@(posedge clk) disable iff (!arst_n)
		front_wr.en |-> (q_empty && !back_busy))
		else $error("ring written while queued work may still read it");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("command pushed into a full queue");

	a_pop_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> back_busy)
		else $error("back part idle after taking a command");

endmodule

// ----- test/tb_top.sv -----
// Testbench for text_head_filter_unit: random and directed text streams checked word by word.
`timescale 1ns / 100ps

module tb_top;
	import thf_pkg::*;

	localparam int SETTLE_CYCLES = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [7:0] out_byte;
		logic       last_of_run;
	} text_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	thf_in_if  in_ch();
	thf_out_if out_ch();

	text_head_filter_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Predicted configuration and filter state
	logic [31:0] head_limit;
	logic        trim_on;
	logic [6:0]  prefix_cols;
	logic        ff_between;
	logic [31:0] lines_seen;
	logic        head_reached;
	logic        text_on_line;
	logic [7:0]  held_ws [32];
	int          held_count;
	logic [4:0]  held_head;
	logic        past_first_file;
	logic        file_open;

	logic [7:0] step_bytes [$];
	text_word_t expected_text_q [$];

	int mismatches = 0;
	int words_checked = 0;
	int items_sent = 0;
	int files_sent = 0;
	int settings_applied = 0;
	int idle_cycles = 0;
	int tx_burst_left = 0;
	bit tx_steady = 1'b0;

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return CH_SP;
			1: return CH_TAB;
			2: return CH_VT;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_text();
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	task automatic start_line_text();
		int cols;
		if (!text_on_line) begin
			cols = (prefix_cols > 7'd80) ? 80 : prefix_cols;
			for (int i = 0; i < cols / 8; i++)
				step_bytes.push_back(CH_TAB);
			for (int i = 0; i < cols % 8; i++)
				step_bytes.push_back(CH_SP);
			text_on_line = 1'b1;
		end
	endtask

	task automatic pop_held_ws();
		step_bytes.push_back(held_ws[held_head]);
		held_head = held_head + 5'd1;
		held_count--;
	endtask

	task automatic release_held_ws();
		if (held_count > 0) begin
			start_line_text();
			while (held_count > 0)
				pop_held_ws();
		end
		held_count = 0;
		held_head = '0;
	endtask

	task automatic predict_filtered_text(input mode_t m, input logic [7:0] b);
		bit trimming;
		bit blank;
		step_bytes.delete();
		if (!file_open) begin
			file_open = 1'b1;
			if (ff_between && past_first_file)
				step_bytes.push_back(CH_FF);
		end
		trimming = trim_on || (prefix_cols != 7'd0);
		blank = (b == CH_SP) || (b == CH_TAB) || (b == CH_VT) || (b == CH_CR);
		if (m == MODE_EOF) begin
			held_count = 0;
			held_head = '0;
			lines_seen = '0;
			head_reached = 1'b0;
			text_on_line = 1'b0;
			past_first_file = 1'b1;
			file_open = 1'b0;
		end else if (!head_reached && b != CH_NUL) begin
			if (b == CH_LF || b == CH_FF) begin
				// drop trailing whitespace when trimming, else pass it on
				if (trimming) begin
					held_count = 0;
					held_head = '0;
				end else begin
					release_held_ws();
				end
				step_bytes.push_back(b);
				text_on_line = 1'b0;
				lines_seen = lines_seen + 32'd1;
				if (lines_seen >= head_limit)
					head_reached = 1'b1;
			end else if (trimming && blank) begin
				// full queue: push out the oldest held byte first
				if (held_count >= WS_DEPTH) begin
					start_line_text();
					pop_held_ws();
				end
				held_ws[held_head + held_count[4:0]] = b;
				held_count++;
			end else begin
				start_line_text();
				release_held_ws();
				step_bytes.push_back(b);
			end
		end
		foreach (step_bytes[i])
			expected_text_q.push_back('{step_bytes[i], i == step_bytes.size() - 1});
	endtask

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic send_item(input mode_t m, input logic [7:0] b);
		int gap;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.in_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		predict_filtered_text(m, b);
		if (!tx_steady) begin
			if (tx_burst_left > 0)
				tx_burst_left--;
			if (tx_burst_left == 0) begin
				tx_burst_left = $urandom_range(1, 8);
				gap = $urandom_range(1, 4);
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_HEAD_LINES:       head_limit = val;
			REG_TRIM_ENABLE:      trim_on = val[0];
			REG_PREFIX_COLUMNS:   prefix_cols = val[6:0];
			REG_FORMFEED_BETWEEN: ff_between = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every expected word is out and the block has drained its queue.
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_text_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [31:0] head, input logic trim,
			input logic [6:0] cols, input logic ff);
		settle();
		write_reg(REG_HEAD_LINES, head);
		write_reg(REG_TRIM_ENABLE, {31'd0, trim});
		write_reg(REG_PREFIX_COLUMNS, {25'd0, cols});
		write_reg(REG_FORMFEED_BETWEEN, {31'd0, ff});
		settings_applied++;
	endtask

	task automatic send_random_file(inout int budget, input bit long_run);
		int n;
		int r;
		int len;
		logic [7:0] b;
		files_sent++;
		tx_steady = ($urandom_range(0, 3) == 0);
		n = $urandom_range(4, 24);
		if (long_run) begin
			// overrun the whitespace queue, optionally with text first
			len = $urandom_range(30, 40);
			if ($urandom_range(0, 1))
				send_item(MODE_DATA, pick_text());
			for (int k = 0; k < len && !head_reached; k++)
				send_item(MODE_DATA, pick_blank());
			send_item(MODE_DATA, pick_text());
			send_item(MODE_DATA, CH_LF);
			budget -= len + 2;
		end
		for (int k = 0; k < n && budget > 0 && !head_reached; k++) begin
			r = $urandom_range(0, 19);
			if (r < 9)
				b = (r == 0) ? 8'($urandom_range(0, 255)) : pick_text();
			else if (r < 15)
				b = pick_blank();
			else if (r < 18)
				b = (r == 17) ? CH_FF : CH_LF;
			else if (r == 18)
				b = CH_NUL;
			else
				b = 8'($urandom_range(0, 255));
			send_item(MODE_DATA, b);
			budget--;
		end
		// bytes past the head are ignored and not counted
		if (head_reached)
			repeat ($urandom_range(0, 2)) send_item(MODE_DATA, 8'($urandom_range(0, 255)));
		send_item(MODE_EOF, 8'($urandom_range(0, 255)));
		budget--;
	endtask

	task automatic run_phase(input logic [31:0] head, input logic trim,
			input logic [6:0] cols, input logic ff, input int budget, input bit long_run);
		bit first;
		apply_settings(head, trim, cols, ff);
		first = long_run;
		while (budget > 0) begin
			send_random_file(budget, first);
			first = 1'b0;
		end
	endtask

	task automatic test_plain_passthrough();
		settings_applied++;
		files_sent += 2;
		send_item(MODE_DATA, 8'h41);
		send_item(MODE_DATA, 8'hFF);
		send_item(MODE_DATA, CH_NUL);
		send_item(MODE_DATA, CH_SP);
		send_item(MODE_DATA, CH_TAB);
		send_item(MODE_DATA, CH_LF);
		send_item(MODE_DATA, 8'h7F);
		send_item(MODE_DATA, CH_FF);
		send_item(MODE_EOF, 8'h00);
		send_item(MODE_EOF, 8'hFF);
	endtask

	task automatic test_trim_and_prefix();
		apply_settings(32'd2, 1'b1, 7'd11, 1'b1);
		files_sent += 3;
		// empty file still gets its formfeed
		send_item(MODE_EOF, 8'h00);
		send_item(MODE_DATA, CH_SP);
		send_item(MODE_DATA, 8'h68);
		send_item(MODE_DATA, CH_SP);
		send_item(MODE_DATA, CH_TAB);
		send_item(MODE_DATA, CH_LF);
		send_item(MODE_DATA, CH_SP);
		send_item(MODE_DATA, CH_CR);
		send_item(MODE_DATA, CH_VT);
		send_item(MODE_DATA, CH_LF);
		send_item(MODE_DATA, 8'h7A);
		send_item(MODE_EOF, 8'h00);
		// unterminated last line
		send_item(MODE_DATA, 8'h71);
		send_item(MODE_DATA, CH_SP);
		send_item(MODE_EOF, 8'h00);
	endtask

	task automatic test_trim_off_midline();
		apply_settings(32'd10, 1'b1, 7'd3, 1'b0);
		files_sent++;
		send_item(MODE_DATA, CH_SP);
		send_item(MODE_DATA, CH_TAB);
		settle();
		write_reg(REG_TRIM_ENABLE, 32'd0);
		write_reg(REG_PREFIX_COLUMNS, 32'd0);
		settings_applied++;
		send_item(MODE_DATA, 8'h78);
		send_item(MODE_DATA, CH_LF);
		send_item(MODE_EOF, 8'h00);
	endtask

	task automatic test_random_phases();
		run_phase(32'd3, 1'b0, 7'd0, 1'b1, 24, 1'b0);
		run_phase(32'd2, 1'b1, 7'd0, 1'b0, 24, 1'b1);
		run_phase(32'hFFFF_FFFF, 1'b0, 7'd80, 1'b1, 24, 1'b1);
		run_phase(32'd1, 1'b1, 7'd127, 1'b1, 24, 1'b0);
		run_phase(32'd0, 1'b1, 7'd7, 1'b0, 24, 1'b0);
		run_phase(32'd5, 1'b0, 7'd0, 1'b0, 24, 1'b0);
	endtask

	// Receiver: stall on a random mask, with some fully ready stretches
	initial begin : receiver
		int slot;
		logic [31:0] mask;
		out_ch.ready = 1'b0;
		slot = 0;
		mask = '1;
		forever begin
			@(negedge clk);
			if (slot == 0)
				mask = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'h0101_0101);
			out_ch.ready <= mask[slot];
			slot = (slot + 1) % 32;
		end
	end

	always @(posedge clk) begin : word_check
		text_word_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			words_checked++;
			if (expected_text_q.size() == 0) begin
				note_failure($sformatf("unexpected word: byte %02h last %0b",
					out_ch.out_byte, out_ch.last_of_run));
			end else begin
				want = expected_text_q.pop_front();
				if (want.out_byte !== out_ch.out_byte || want.last_of_run !== out_ch.last_of_run)
					note_failure($sformatf(
						"word %0d: expected byte %02h last %0b, got byte %02h last %0b",
						words_checked, want.out_byte, want.last_of_run,
						out_ch.out_byte, out_ch.last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_DATA;
		in_ch.in_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_index = REG_HEAD_LINES;
		cfg_data = 32'd0;
		head_limit = 32'd10;
		trim_on = 1'b0;
		prefix_cols = 7'd0;
		ff_between = 1'b0;
		lines_seen = '0;
		head_reached = 1'b0;
		text_on_line = 1'b0;
		foreach (held_ws[i])
			held_ws[i] = 8'h00;
		held_count = 0;
		held_head = '0;
		past_first_file = 1'b0;
		file_open = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_plain_passthrough();
		test_trim_and_prefix();
		test_trim_off_midline();
		test_random_phases();

		settle();
		if (expected_text_q.size() != 0) begin
			mismatches += expected_text_q.size();
			$display("%0d expected words never arrived", expected_text_q.size());
		end
		$display("Sent %0d items in %0d files under %0d register settings",
			items_sent, files_sent, settings_applied);
		$display("Checked %0d output words, %0d mismatches", words_checked, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/thf_pkg.sv
rtl/thf_ifs.sv
rtl/thf_ram.sv
rtl/thf_queue.sv
rtl/thf_front.sv
rtl/thf_back.sv
rtl/text_head_filter_unit.sv
test/tb_top.sv
